>>> rtl/r2q_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the rotation matrix to quaternion unit.
package r2q_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned MAG_W     = 17;

  typedef enum logic [1:0] {
    PIV_W = 2'd0,
    PIV_X = 2'd1,
    PIV_Y = 2'd2,
    PIV_Z = 2'd3
  } pivot_e;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [1:0]         pivot;
    logic               degenerate;
  } out_t;

  // Non-pivot components in x, y, z, w order with the pivot left out.
  typedef struct packed {
    pivot_e                 pivot;
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  mag;
  } side_t;

  function automatic logic [MAG_W-1:0] mag17(logic signed [17:0] d);
    logic signed [17:0] n;
    begin
      n = -d;
      mag17 = d[17] ? n[MAG_W-1:0] : d[MAG_W-1:0];
    end
  endfunction

endpackage

>>> rtl/r2q_front.sv
`timescale 1ns / 1ps
// Pivot selection, root argument and numerator stage.
module r2q_front #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS,
  parameter int unsigned ARG_W     = 19
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  r2q_pkg::in_t         mat_i,
  output logic                 valid_o,
  output logic [ARG_W-1:0]     arg_o,
  output r2q_pkg::side_t       side_o
);

  localparam int unsigned SW = ARG_W + 1;
  localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

  logic signed [SW-1:0] e00, e11, e22, trace, arg;
  logic signed [17:0]   dxa, dyb, dzc, s01, s02, s12;
  logic signed [17:0]   o0, o1, o2;
  r2q_pkg::pivot_e      piv;
  logic                 deg;

  logic                 valid_q;
  logic [ARG_W-1:0]     arg_q;
  r2q_pkg::side_t       side_q, side_d;
  logic [ARG_W-1:0]     arg_d;

  always_comb begin
    e00   = SW'(mat_i.m00);
    e11   = SW'(mat_i.m11);
    e22   = SW'(mat_i.m22);
    trace = e00 + e11 + e22;
    dxa   = 18'(mat_i.m21) - 18'(mat_i.m12);
    dyb   = 18'(mat_i.m02) - 18'(mat_i.m20);
    dzc   = 18'(mat_i.m10) - 18'(mat_i.m01);
    s01   = 18'(mat_i.m01) + 18'(mat_i.m10);
    s02   = 18'(mat_i.m02) + 18'(mat_i.m20);
    s12   = 18'(mat_i.m12) + 18'(mat_i.m21);
    if (trace > 0) begin
      piv = r2q_pkg::PIV_W;
    end else if ((mat_i.m00 > mat_i.m11) && (mat_i.m00 > mat_i.m22)) begin
      piv = r2q_pkg::PIV_X;
    end else if (mat_i.m11 > mat_i.m22) begin
      piv = r2q_pkg::PIV_Y;
    end else begin
      piv = r2q_pkg::PIV_Z;
    end
    case (piv)
      r2q_pkg::PIV_W: begin
        arg = trace + $signed(ONE);
        o0 = dxa; o1 = dyb; o2 = dzc;
      end
      r2q_pkg::PIV_X: begin
        arg = $signed(ONE) + e00 - e11 - e22;
        o0 = s01; o1 = s02; o2 = dxa;
      end
      r2q_pkg::PIV_Y: begin
        arg = $signed(ONE) + e11 - e00 - e22;
        o0 = s01; o1 = s12; o2 = dyb;
      end
      default: begin
        arg = $signed(ONE) + e22 - e00 - e11;
        o0 = s02; o1 = s12; o2 = dzc;
      end
    endcase
    deg             = (arg <= 0);
    arg_d           = deg ? '0 : arg[ARG_W-1:0];
    side_d.pivot    = piv;
    side_d.degen    = deg;
    side_d.neg      = {o2[17], o1[17], o0[17]};
    side_d.mag[0]   = r2q_pkg::mag17(o0);
    side_d.mag[1]   = r2q_pkg::mag17(o1);
    side_d.mag[2]   = r2q_pkg::mag17(o2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      arg_q  <= arg_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign arg_o   = arg_q;
  assign side_o  = side_q;

endmodule

>>> rtl/r2q_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage.
module r2q_sqrt #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS,
  parameter int unsigned ARG_W     = 19,
  parameter int unsigned ROOT_W    = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  logic [ARG_W-1:0]     arg_i,
  input  r2q_pkg::side_t       side_i,
  output logic                 valid_o,
  output logic [ROOT_W-1:0]    root_o,
  output r2q_pkg::side_t       side_o
);

  localparam int unsigned VW    = 2 * ROOT_W;
  localparam int unsigned REM_W = ROOT_W + 3;

  logic [VW-1:0]     v_q    [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  r2q_pkg::side_t    side_q [ROOT_W];
  logic              vld_q  [ROOT_W];

  logic [VW-1:0]     v_d    [ROOT_W];
  logic [REM_W-1:0]  rem_d  [ROOT_W];
  logic [ROOT_W-1:0] root_d [ROOT_W];

  always_comb begin
    logic [VW-1:0]     vin;
    logic [REM_W-1:0]  rin;
    logic [ROOT_W-1:0] oin;
    logic [REM_W-1:0]  sh;
    logic [REM_W-1:0]  trial;
    logic              take;
    for (int s = 0; s < ROOT_W; s++) begin
      if (s == 0) begin
        vin = VW'(arg_i) << FRAC_BITS;
        rin = '0;
        oin = '0;
      end else begin
        vin = v_q[s-1];
        rin = rem_q[s-1];
        oin = root_q[s-1];
      end
      sh        = {rin[REM_W-3:0], vin[VW-1 -: 2]};
      trial     = REM_W'({oin, 2'b01});
      take      = (sh >= trial);
      rem_d[s]  = take ? (sh - trial) : sh;
      root_d[s] = {oin[ROOT_W-2:0], take};
      v_d[s]    = vin << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ROOT_W; s++) vld_q[s] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < ROOT_W; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < ROOT_W; s++) side_q[s] <= side_q[s-1];
      for (int s = 0; s < ROOT_W; s++) begin
        v_q[s]    <= v_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

>>> rtl/r2q_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for the three non-pivot components.
module r2q_div #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS,
  parameter int unsigned ROOT_W    = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [ROOT_W-1:0]         root_i,
  input  r2q_pkg::side_t            side_i,
  output logic                      valid_o,
  output logic [ROOT_W-1:0]         root_o,
  output r2q_pkg::side_t            side_o,
  output logic [2:0][FRAC_BITS:0]   quo_o,
  output logic [2:0]                ovf_o
);

  localparam int unsigned NW = r2q_pkg::MAG_W + FRAC_BITS + 1;
  localparam int unsigned DW = ROOT_W + FRAC_BITS + 2;
  localparam int unsigned CW = (DW > NW) ? DW : NW;
  localparam int unsigned DS = FRAC_BITS + 3;

  logic                      vld_q  [DS];
  r2q_pkg::side_t            side_q [DS];
  logic [ROOT_W-1:0]         root_q [DS];
  logic [CW-1:0]             den_q  [DS];
  logic [2:0][CW-1:0]        rem_q  [DS];
  logic [2:0][FRAC_BITS:0]   quo_q  [DS];
  logic [2:0]                ovf_q  [DS];

  logic [CW-1:0]             den_d  [DS];
  logic [2:0][CW-1:0]        rem_d  [DS];
  logic [2:0][FRAC_BITS:0]   quo_d  [DS];
  logic [2:0]                ovf_d  [DS];

  always_comb begin
    logic [CW-1:0] trial;
    logic          bit_q;
    for (int s = 0; s < DS; s++) begin
      if (s == 0) begin
        den_d[s] = CW'({root_i, 1'b0});
        quo_d[s] = '0;
        ovf_d[s] = '0;
        for (int c = 0; c < 3; c++) begin
          rem_d[s][c] = (CW'(side_i.mag[c]) << FRAC_BITS) + CW'(root_i);
        end
      end else if (s == 1) begin
        den_d[s] = den_q[s-1];
        quo_d[s] = quo_q[s-1];
        rem_d[s] = rem_q[s-1];
        for (int c = 0; c < 3; c++) begin
          ovf_d[s][c] = (rem_q[s-1][c] >= (den_q[s-1] << (FRAC_BITS + 1)));
        end
      end else begin
        den_d[s] = den_q[s-1];
        ovf_d[s] = ovf_q[s-1];
        trial    = den_q[s-1] << (FRAC_BITS + 2 - s);
        for (int c = 0; c < 3; c++) begin
          bit_q       = (rem_q[s-1][c] >= trial);
          rem_d[s][c] = bit_q ? (rem_q[s-1][c] - trial) : rem_q[s-1][c];
          quo_d[s][c] = {quo_q[s-1][c][FRAC_BITS-1:0], bit_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DS; s++) vld_q[s] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
      for (int s = 1; s < DS; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      side_q[0] <= side_i;
      root_q[0] <= root_i;
      for (int s = 1; s < DS; s++) begin
        side_q[s] <= side_q[s-1];
        root_q[s] <= root_q[s-1];
      end
      for (int s = 0; s < DS; s++) begin
        den_q[s] <= den_d[s];
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        ovf_q[s] <= ovf_d[s];
      end
    end
  end

  assign valid_o = vld_q[DS-1];
  assign root_o  = root_q[DS-1];
  assign side_o  = side_q[DS-1];
  assign quo_o   = quo_q[DS-1];
  assign ovf_o   = ovf_q[DS-1];

endmodule

>>> rtl/rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 1ps
// Top level of the rotation matrix to quaternion unit (Shepperd's method).
//
//   channel  direction  handshake                word
//   in       sink       in_valid_i / in_stall_o  r2q_pkg::in_t  (nine matrix entries)
//   out      source     out_valid_o / out_stall_i r2q_pkg::out_t (quaternion, pivot, flag)
//
// One word per cycle is taken while the output is not stalled; each word passes the front
// register, the bit-per-stage root and divider pipelines and the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output word freezes every stage and stalls the input.
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  r2q_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output r2q_pkg::out_t  out_data_o
);

  localparam int unsigned ARG_W  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int unsigned ROOT_W = (ARG_W + FRAC_BITS + 1) / 2;
  localparam int unsigned QW     = FRAC_BITS + 1;
  localparam int unsigned HW     = (ROOT_W + 1 > QW) ? ROOT_W + 1 : QW;
  localparam logic [QW-1:0] ONE  = QW'(1) << FRAC_BITS;

  logic                    adv;
  logic                    f_valid, s_valid, d_valid;
  logic [ARG_W-1:0]        f_arg;
  r2q_pkg::side_t          f_side, s_side, d_side;
  logic [ROOT_W-1:0]       s_root, d_root;
  logic [2:0][FRAC_BITS:0] d_quo;
  logic [2:0]              d_ovf;

  logic                    out_valid_q;
  r2q_pkg::out_t           out_q, out_d;

  function automatic logic signed [15:0] to16(logic neg, logic [QW-1:0] m);
    logic [QW+16:0] ext;
    logic [QW+16:0] n;
    begin
      ext = (QW + 17)'(m);
      n   = -ext;
      if (!neg) begin
        to16 = (ext > (QW + 17)'(32767)) ? 16'sh7fff : ext[15:0];
      end else begin
        to16 = (ext > (QW + 17)'(32768)) ? 16'sh8000 : n[15:0];
      end
    end
  endfunction

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  r2q_front #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .mat_i   (in_data_i),
    .valid_o (f_valid),
    .arg_o   (f_arg),
    .side_o  (f_side)
  );

  r2q_sqrt #(.FRAC_BITS(FRAC_BITS), .ARG_W(ARG_W), .ROOT_W(ROOT_W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_valid),
    .arg_i   (f_arg),
    .side_i  (f_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  r2q_div #(.FRAC_BITS(FRAC_BITS), .ROOT_W(ROOT_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (s_valid),
    .root_i  (s_root),
    .side_i  (s_side),
    .valid_o (d_valid),
    .root_o  (d_root),
    .side_o  (d_side),
    .quo_o   (d_quo),
    .ovf_o   (d_ovf)
  );

  always_comb begin
    logic [HW-1:0]           half;
    logic [QW-1:0]           hm;
    logic [2:0][QW-1:0]      mq;
    logic signed [15:0]      hp;
    logic signed [15:0]      c0, c1, c2;
    half = (HW'(d_root) + HW'(1)) >> 1;
    hm   = (half > HW'(ONE)) ? ONE : half[QW-1:0];
    for (int c = 0; c < 3; c++) begin
      mq[c] = (d_ovf[c] || (d_quo[c] > ONE)) ? ONE : d_quo[c];
    end
    hp = to16(1'b0, hm);
    c0 = to16(d_side.neg[0], mq[0]);
    c1 = to16(d_side.neg[1], mq[1]);
    c2 = to16(d_side.neg[2], mq[2]);
    case (d_side.pivot)
      r2q_pkg::PIV_W: begin
        out_d.qx = c0; out_d.qy = c1; out_d.qz = c2; out_d.qw = hp;
      end
      r2q_pkg::PIV_X: begin
        out_d.qx = hp; out_d.qy = c0; out_d.qz = c1; out_d.qw = c2;
      end
      r2q_pkg::PIV_Y: begin
        out_d.qx = c0; out_d.qy = hp; out_d.qz = c1; out_d.qw = c2;
      end
      default: begin
        out_d.qx = c0; out_d.qy = c1; out_d.qz = hp; out_d.qw = c2;
      end
    endcase
    if (d_side.degen) begin
      out_d.qx = '0; out_d.qy = '0; out_d.qz = '0; out_d.qw = '0;
    end
    out_d.pivot      = d_side.pivot;
    out_d.degenerate = d_side.degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/r2q_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the rotation matrix to quaternion unit, with its bind.
module r2q_checker #(
  parameter int unsigned FRAC_BITS = r2q_pkg::FRAC_BITS
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input r2q_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input r2q_pkg::out_t out_data_o
);

  localparam int HI = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
  localparam int LO = (FRAC_BITS >= 15) ? -32768 : -(1 << FRAC_BITS);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output word valid during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.qx == 0 && out_data_o.qy == 0 &&
      out_data_o.qz == 0 && out_data_o.qw == 0)
    else $error("degenerate word carries non-zero quaternion");

  a_trace_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pivot == r2q_pkg::PIV_W |->
      !out_data_o.degenerate && out_data_o.qw > 0)
    else $error("trace pivot word without positive w");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.qx <= HI && out_data_o.qx >= LO &&
      out_data_o.qy <= HI && out_data_o.qy >= LO &&
      out_data_o.qz <= HI && out_data_o.qz >= LO &&
      out_data_o.qw <= HI && out_data_o.qw >= LO)
    else $error("quaternion component out of range");

endmodule

bind rotation_matrix_to_quaternion_unit r2q_checker #(.FRAC_BITS(FRAC_BITS)) u_r2q_checker (.*);
